/* src/stk_pkg.sv */
// Package with the word types, codes and character tables of the source byte tokenizer.
`timescale 1ns / 1ps
package stk_pkg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] source_byte;
    } t_in;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [2:0]  error_code;
        logic [7:0]  bad_byte;
        logic [23:0] start_line;
        logic [15:0] start_column;
        logic [23:0] start_offset;
        logic [15:0] token_length;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic two;
        t_out r0;
        t_out r1;
    } t_pair;

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_INT, M_ZERO, M_OP, M_COMMENT, M_ABSORB, M_DEAD
    } t_mode;

    localparam logic [5:0] KIND_EOF   = 6'd0;
    localparam logic [5:0] KIND_IDENT = 6'd1;
    localparam logic [5:0] KIND_INT   = 6'd2;
    localparam logic [5:0] KIND_KW0   = 6'd3;
    localparam logic [5:0] KIND_SLASH = 6'd30;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_BYTE  = 3'd1;
    localparam logic [2:0] ERR_AMP   = 3'd2;
    localparam logic [2:0] ERR_BAR   = 3'd3;
    localparam logic [2:0] ERR_ZERO  = 3'd4;

    localparam logic [7:0] CH_US    = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;

    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
    localparam logic [15:0] COL_MAX  = 16'hFFFF;
    localparam logic [15:0] LEN_MAX  = 16'hFFFF;

    localparam int NUM_KW = 16;

    // Keyword text is right aligned: the first character sits in the highest used byte.
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'("class"), 64'("extends"), 64'("if"), 64'("else"),
        64'("while"), 64'("return"), 64'("break"), 64'("continue"),
        64'("true"), 64'("false"), 64'("int"), 64'("bool"),
        64'("void"), 64'("this"), 64'("super"), 64'("null")
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd5, 4'd7, 4'd2, 4'd4, 4'd5, 4'd6, 4'd5, 4'd8,
        4'd4, 4'd5, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5, 4'd4
    };

    function automatic logic is_alpha(input logic [7:0] b);
        is_alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == CH_US;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        is_space = b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function automatic logic is_op2(input logic [7:0] b);
        is_op2 = b == CH_SLASH || b == CH_EQ || b == 8'h21 || b == 8'h3C || b == 8'h3E
            || b == CH_AMP || b == CH_BAR;
    endfunction

    function automatic logic [5:0] single_op(input logic [7:0] b);
        case (b)
            8'h28: single_op = 6'd19;
            8'h29: single_op = 6'd20;
            8'h7B: single_op = 6'd21;
            8'h7D: single_op = 6'd22;
            8'h2C: single_op = 6'd23;
            8'h3B: single_op = 6'd24;
            8'h3A: single_op = 6'd25;
            8'h2E: single_op = 6'd26;
            8'h2B: single_op = 6'd27;
            8'h2D: single_op = 6'd28;
            8'h2A: single_op = 6'd29;
            8'h2F: single_op = 6'd30;
            8'h25: single_op = 6'd31;
            8'h3D: single_op = 6'd32;
            8'h21: single_op = 6'd41;
            8'h3C: single_op = 6'd35;
            8'h3E: single_op = 6'd37;
            default: single_op = 6'd0;
        endcase
    endfunction

    function automatic logic [5:0] double_op(input logic [7:0] b);
        case (b)
            8'h3D: double_op = 6'd33;
            8'h21: double_op = 6'd34;
            8'h3C: double_op = 6'd36;
            8'h3E: double_op = 6'd38;
            8'h26: double_op = 6'd39;
            default: double_op = 6'd40;
        endcase
    endfunction

endpackage

/* src/stk_front.sv */
// Scanner front end: classifies each source byte, tracks positions and builds result pairs.
`timescale 1ns / 1ps
module stk_front #(
    parameter int KEYWORD_PREFIX_BYTES = 8,
    parameter int OFFSET_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  stk_pkg::t_in  i_word,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic          i_cfg_val,
    output logic          o_first_line,
    output logic          o_first_column,
    output logic          o_push,
    output stk_pkg::t_pair o_pair
);
    localparam int PW = $clog2(KEYWORD_PREFIX_BYTES);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    stk_pkg::t_mode r_mode, n_mode;
    logic [7:0] r_pend, n_pend;
    logic [7:0] r_pfx [KEYWORD_PREFIX_BYTES];
    logic [23:0] r_tsl, n_tsl, r_cl, n_cl;
    logic [15:0] r_tsc, n_tsc, r_cc, n_cc, r_tc, n_tc;
    logic [OFFSET_BITS-1:0] r_tso, n_tso, r_co, n_co;
    logic r_first_line, r_first_col;
    logic [5:0] w_ident_kind;
    logic pfx_we;
    logic [PW-1:0] pfx_wi;
    stk_pkg::t_out res [2];
    logic [1:0] cnt;
    logic do_start, do_step;
    logic [7:0] b;

    function automatic logic [23:0] sat_off(input logic [OFFSET_BITS-1:0] v);
        logic [32:0] e;
        e = 33'(v);
        sat_off = (e > 33'h0FFFFFF) ? 24'hFFFFFF : e[23:0];
    endfunction

    function automatic stk_pkg::t_out mk(input logic [5:0] k, input logic [2:0] e,
        input logic [7:0] bb, input logic [23:0] l, input logic [15:0] c,
        input logic [OFFSET_BITS-1:0] o, input logic [15:0] n);
        stk_pkg::t_out r;
        r.token_kind = k;
        r.error_code = e;
        r.bad_byte = bb;
        r.start_line = l;
        r.start_column = c;
        r.start_offset = sat_off(o);
        r.token_length = n;
        r.last_of_run = 1'b0;
        mk = r;
    endfunction

    always_comb begin
        w_ident_kind = stk_pkg::KIND_IDENT;
        for (int i = stk_pkg::NUM_KW - 1; i >= 0; i--) begin
            logic hit;
            hit = (r_tc == 16'(stk_pkg::KW_LEN[i]));
            for (int j = 0; j < 8; j++) begin
                if (j < int'(stk_pkg::KW_LEN[i]) && j < KEYWORD_PREFIX_BYTES) begin
                    if (r_pfx[j] != stk_pkg::KW_TEXT[i][8*(int'(stk_pkg::KW_LEN[i])-1-j) +: 8])
                        hit = 1'b0;
                end
            end
            if (hit) w_ident_kind = stk_pkg::KIND_KW0 + 6'(i);
        end
    end

    always_comb begin
        n_mode = r_mode; n_pend = r_pend;
        n_tsl = r_tsl; n_tsc = r_tsc; n_tso = r_tso; n_tc = r_tc;
        n_cl = r_cl; n_cc = r_cc; n_co = r_co;
        res[0] = '0; res[1] = '0; cnt = 2'd0;
        pfx_we = 1'b0; pfx_wi = '0;
        do_start = 1'b0; do_step = 1'b0;
        b = i_word.source_byte;
        if (i_word.req_type) begin
            case (r_mode)
                stk_pkg::M_IDENT: begin
                    res[0] = mk(w_ident_kind, stk_pkg::ERR_NONE, 8'd0, r_tsl, r_tsc, r_tso, r_tc);
                    cnt = 2'd1;
                end
                stk_pkg::M_INT, stk_pkg::M_ZERO: begin
                    res[0] = mk(stk_pkg::KIND_INT, stk_pkg::ERR_NONE, 8'd0, r_tsl, r_tsc,
                        r_tso, r_tc);
                    cnt = 2'd1;
                end
                stk_pkg::M_OP: begin
                    if (r_pend == stk_pkg::CH_AMP)
                        res[0] = mk(stk_pkg::KIND_EOF, stk_pkg::ERR_AMP, 8'd0, r_tsl, r_tsc,
                            r_tso, 16'd0);
                    else if (r_pend == stk_pkg::CH_BAR)
                        res[0] = mk(stk_pkg::KIND_EOF, stk_pkg::ERR_BAR, 8'd0, r_tsl, r_tsc,
                            r_tso, 16'd0);
                    else
                        res[0] = mk(stk_pkg::single_op(r_pend), stk_pkg::ERR_NONE, 8'd0, r_tsl,
                            r_tsc, r_tso, r_tc);
                    cnt = 2'd1;
                end
                default: cnt = 2'd0;
            endcase
            res[cnt[0]] = mk(stk_pkg::KIND_EOF, stk_pkg::ERR_NONE, 8'd0, r_cl, r_cc, r_co, 16'd0);
            cnt = cnt + 2'd1;
            n_mode = stk_pkg::M_IDLE; n_pend = 8'd0;
            n_tsl = '0; n_tsc = '0; n_tso = '0; n_tc = '0;
            n_cl = 24'(r_first_line); n_cc = 16'(r_first_col); n_co = '0;
        end else begin
            case (r_mode)
                stk_pkg::M_IDENT: begin
                    if (stk_pkg::is_alpha(b) || stk_pkg::is_digit(b)) begin
                        if (r_tc < 16'(KEYWORD_PREFIX_BYTES)) begin
                            pfx_we = 1'b1;
                            pfx_wi = r_tc[PW-1:0];
                        end
                        if (r_tc < stk_pkg::LEN_MAX) n_tc = r_tc + 16'd1;
                        do_step = 1'b1;
                    end else begin
                        res[0] = mk(w_ident_kind, stk_pkg::ERR_NONE, 8'd0, r_tsl, r_tsc, r_tso,
                            r_tc);
                        cnt = 2'd1;
                        do_start = 1'b1;
                    end
                end
                stk_pkg::M_INT: begin
                    if (stk_pkg::is_digit(b)) begin
                        if (r_tc < stk_pkg::LEN_MAX) n_tc = r_tc + 16'd1;
                        do_step = 1'b1;
                    end else begin
                        res[0] = mk(stk_pkg::KIND_INT, stk_pkg::ERR_NONE, 8'd0, r_tsl, r_tsc,
                            r_tso, r_tc);
                        cnt = 2'd1;
                        do_start = 1'b1;
                    end
                end
                stk_pkg::M_ZERO: begin
                    if (stk_pkg::is_digit(b)) begin
                        res[0] = mk(stk_pkg::KIND_EOF, stk_pkg::ERR_ZERO, 8'd0, r_tsl, r_tsc,
                            r_tso, 16'd0);
                        cnt = 2'd1;
                        n_mode = stk_pkg::M_ABSORB;
                        do_step = 1'b1;
                    end else begin
                        res[0] = mk(stk_pkg::KIND_INT, stk_pkg::ERR_NONE, 8'd0, r_tsl, r_tsc,
                            r_tso, r_tc);
                        cnt = 2'd1;
                        do_start = 1'b1;
                    end
                end
                stk_pkg::M_OP: begin
                    if (r_pend == stk_pkg::CH_SLASH) begin
                        if (b == stk_pkg::CH_SLASH) begin
                            n_mode = stk_pkg::M_COMMENT;
                            do_step = 1'b1;
                        end else begin
                            res[0] = mk(stk_pkg::KIND_SLASH, stk_pkg::ERR_NONE, 8'd0, r_tsl,
                                r_tsc, r_tso, r_tc);
                            cnt = 2'd1;
                            n_pend = 8'd0;
                            do_start = 1'b1;
                        end
                    end else if (r_pend == stk_pkg::CH_AMP || r_pend == stk_pkg::CH_BAR) begin
                        n_pend = 8'd0;
                        cnt = 2'd1;
                        if (b == r_pend) begin
                            n_tc = 16'd2;
                            res[0] = mk(stk_pkg::double_op(r_pend), stk_pkg::ERR_NONE, 8'd0,
                                r_tsl, r_tsc, r_tso, 16'd2);
                            n_mode = stk_pkg::M_IDLE;
                            do_step = 1'b1;
                        end else begin
                            res[0] = mk(stk_pkg::KIND_EOF, (r_pend == stk_pkg::CH_AMP) ?
                                stk_pkg::ERR_AMP : stk_pkg::ERR_BAR, 8'd0, r_tsl, r_tsc, r_tso,
                                16'd0);
                            n_mode = stk_pkg::M_DEAD;
                        end
                    end else if (b == stk_pkg::CH_EQ) begin
                        n_tc = 16'd2;
                        res[0] = mk(stk_pkg::double_op(r_pend), stk_pkg::ERR_NONE, 8'd0, r_tsl,
                            r_tsc, r_tso, 16'd2);
                        cnt = 2'd1;
                        n_mode = stk_pkg::M_IDLE;
                        n_pend = 8'd0;
                        do_step = 1'b1;
                    end else begin
                        res[0] = mk(stk_pkg::single_op(r_pend), stk_pkg::ERR_NONE, 8'd0, r_tsl,
                            r_tsc, r_tso, r_tc);
                        cnt = 2'd1;
                        n_pend = 8'd0;
                        do_start = 1'b1;
                    end
                end
                stk_pkg::M_COMMENT: begin
                    if (b != stk_pkg::CH_LF) do_step = 1'b1;
                    else do_start = 1'b1;
                end
                stk_pkg::M_ABSORB: begin
                    if (stk_pkg::is_digit(b)) do_step = 1'b1;
                    else n_mode = stk_pkg::M_DEAD;
                end
                stk_pkg::M_DEAD: do_step = 1'b0;
                default: do_start = 1'b1;
            endcase
            if (do_start) begin
                n_mode = stk_pkg::M_IDLE;
                n_tsl = r_cl; n_tsc = r_cc; n_tso = r_co; n_tc = 16'd1;
                do_step = 1'b1;
                if (stk_pkg::is_space(b)) begin
                    n_tc = 16'd0;
                end else if (stk_pkg::is_alpha(b)) begin
                    pfx_we = 1'b1;
                    pfx_wi = '0;
                    n_mode = stk_pkg::M_IDENT;
                end else if (b == stk_pkg::CH_ZERO) begin
                    n_mode = stk_pkg::M_ZERO;
                end else if (stk_pkg::is_digit(b)) begin
                    n_mode = stk_pkg::M_INT;
                end else if (stk_pkg::is_op2(b)) begin
                    n_pend = b;
                    n_mode = stk_pkg::M_OP;
                end else if (stk_pkg::single_op(b) != 6'd0) begin
                    res[cnt[0]] = mk(stk_pkg::single_op(b), stk_pkg::ERR_NONE, 8'd0, r_cl, r_cc,
                        r_co, 16'd1);
                    cnt = cnt + 2'd1;
                end else begin
                    res[cnt[0]] = mk(stk_pkg::KIND_EOF, stk_pkg::ERR_BYTE, b, r_cl, r_cc, r_co,
                        16'd0);
                    cnt = cnt + 2'd1;
                    n_mode = stk_pkg::M_DEAD;
                end
            end
            if (do_step) begin
                if (b == stk_pkg::CH_LF) begin
                    if (r_cl < stk_pkg::LINE_MAX) n_cl = r_cl + 24'd1;
                    n_cc = 16'(r_first_col);
                end else if (r_cc < stk_pkg::COL_MAX) begin
                    n_cc = r_cc + 16'd1;
                end
                if (r_co < OFF_MAX) n_co = r_co + OFFSET_BITS'(1);
            end
        end
        if (cnt == 2'd2) res[1].last_of_run = 1'b1;
        else res[0].last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stk_pkg::M_IDLE;
            r_pend <= 8'd0;
            r_tsl <= '0; r_tsc <= '0; r_tso <= '0; r_tc <= '0;
            r_cl <= 24'd1; r_cc <= 16'd1; r_co <= '0;
            r_first_line <= 1'b1;
            r_first_col <= 1'b1;
        end else if (i_cfg_we) begin
            if (!i_cfg_idx) begin
                r_first_line <= i_cfg_val;
                if (r_co == '0) r_cl <= 24'(i_cfg_val);
            end else begin
                r_first_col <= i_cfg_val;
                if (r_co == '0) r_cc <= 16'(i_cfg_val);
            end
        end else if (i_acc) begin
            r_mode <= n_mode; r_pend <= n_pend;
            r_tsl <= n_tsl; r_tsc <= n_tsc; r_tso <= n_tso; r_tc <= n_tc;
            r_cl <= n_cl; r_cc <= n_cc; r_co <= n_co;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && !i_cfg_we && pfx_we) r_pfx[pfx_wi] <= b;
    end

    assign o_push = i_acc && !i_cfg_we && cnt != 2'd0;
    assign o_pair.two = cnt == 2'd2;
    assign o_pair.r0 = res[0];
    assign o_pair.r1 = res[1];
    assign o_first_line = r_first_line;
    assign o_first_column = r_first_col;
endmodule

/* src/stk_queue.sv */
// Four-entry queue of result pairs between the scanner and the output stage.
`timescale 1ns / 1ps
module stk_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  stk_pkg::t_pair i_pair,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output stk_pkg::t_pair o_head
);
    stk_pkg::t_pair r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_pair;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

    assign o_full = r_cnt == 3'd4;
    assign o_empty = r_cnt == 3'd0;
    assign o_head = r_mem[r_rp];
endmodule

/* src/stk_back.sv */
// Output stage: splits queued pairs into single result words held in an output register.
`timescale 1ns / 1ps
module stk_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  stk_pkg::t_pair i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output stk_pkg::t_out  o_data
);
    logic r_valid, r_phase;
    stk_pkg::t_out r_data;
    logic w_load;

    assign w_load = !i_empty && (!r_valid || !i_stall);
    assign o_pop = w_load && (r_phase || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_phase <= !r_phase && i_head.two;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_data <= r_phase ? i_head.r1 : i_head.r0;
    end

    assign o_valid = r_valid;
    assign o_data = r_data;
endmodule

/* src/source_byte_tokenizer_core.sv */
// Top level of the source byte tokenizer: scanner, result queue, output stage and register port.
`timescale 1ns / 1ps
// The tokenizer takes one source byte or end marker per cycle and gives up to two result
// words for it. The scanner decides each byte combinationally; its results wait in a
// four-entry queue, and the output stage sends one word per cycle unless stalled, so a byte
// that causes two results is sent as two words. Input is held off only while the queue is full.
// Registers: first_line at byte address 0, first_column at 4; write them while idle.
module source_byte_tokenizer_core #(
    parameter int KEYWORD_PREFIX_BYTES = 8,
    parameter int OFFSET_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  stk_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output stk_pkg::t_out o_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    logic w_acc, w_push, w_pop, w_full, w_empty, w_cfg_we, w_fl, w_fc;
    stk_pkg::t_pair w_pair, w_head;

    assign pready = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;
    assign prdata = {31'd0, paddr[2] ? w_fc : w_fl};
    assign o_stall = w_full;
    assign w_acc = i_valid && !w_full;

    stk_front #(
        .KEYWORD_PREFIX_BYTES(KEYWORD_PREFIX_BYTES),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_acc(w_acc), .i_word(i_data),
        .i_cfg_we(w_cfg_we), .i_cfg_idx(paddr[2]), .i_cfg_val(pwdata[0]),
        .o_first_line(w_fl), .o_first_column(w_fc), .o_push(w_push), .o_pair(w_pair)
    );

    stk_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_pair(w_pair), .i_pop(w_pop),
        .o_full(w_full), .o_empty(w_empty), .o_head(w_head)
    );

    stk_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_empty), .i_head(w_head), .o_pop(w_pop),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty)) else $error("queue underflow");
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.token_kind == stk_pkg::KIND_EOF
            && o_data.error_code == stk_pkg::ERR_NONE) |-> o_data.last_of_run)
        else $error("end of file word not last");
`endif
endmodule
